[sv/ple_pkg.sv]
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

    // Operation codes carried on the request func field
    typedef enum logic [2:0] {
        FUNC_INS_FRONT = 3'd0,
        FUNC_INS_BACK  = 3'd1,
        FUNC_DEL_FRONT = 3'd2,
        FUNC_DEL_BACK  = 3'd3,
        FUNC_INS_AT    = 3'd4,
        FUNC_DEL_AT    = 3'd5,
        FUNC_READ_ALL  = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    // Cell chain operation for one cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_dp_op;

    // Source of the target index
    typedef enum logic [1:0] {
        WH_FRONT = 2'd0,
        WH_BACK  = 2'd1,
        WH_POS   = 2'd2
    } t_where;

    // Controller to datapath
    typedef struct packed {
        t_dp_op  op;
        t_where  where;
        logic    rd_start;
        logic    out_load;
        logic    out_elem;
        t_status status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic ins_pos_ok;
        logic del_pos_ok;
        logic rd_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[sv/positional_list_engine_core.sv]
// Top level of the positional list engine: ordered list with positional insert and delete.
//
// Usage:
//   Request channel: i_valid / o_stall with i_func, i_value, i_position. A request is
//   taken at a rising edge with i_valid high and o_stall low.
//   Result channel: o_valid / i_stall with o_status, o_element_count,
//   o_element_value, o_element_valid, o_last. A result is taken when o_valid is high
//   and i_stall low.
//   Insert and delete requests finish in the accept cycle: the list lives in a chain
//   of DEPTH cells that all shift at once, so each such request gives one result in
//   the next cycle; while results drain, a new request may follow every cycle unless
//   the receiver stalls. Read-all gives count results, one per cycle, from the front
//   cell while the first count cells rotate by one; the list is back in order after
//   the last one. Results wait while the receiver stalls; no request is taken meanwhile.
//   Reset (synchronous, active low) empties the list and drops any pending result.
//   While the receiver stalls, the result register holds and o_stall rises so that
//   no further request is taken.
`default_nettype none

module positional_list_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [2:0]  i_func,
    input  logic signed [31:0] i_value,
    input  logic        [4:0]  i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [1:0]  o_status,
    output logic        [4:0]  o_element_count,
    output logic signed [31:0] o_element_value,
    output logic               o_element_valid,
    output logic               o_last
);
    import ple_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // decode requests and sequence read-out
    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold the cell chain, the count and the result register
    ple_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_element_value (o_element_value),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

[sv/ple_dp.sv]
// Datapath of the positional list engine: cell chain, count and result register.
`default_nettype none

module ple_dp #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ple_pkg::t_cmd         i_cmd,
    output ple_pkg::t_stat        o_stat,
    input  logic signed [31:0]    i_value,
    input  logic        [4:0]     i_position,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic        [1:0]     o_status,
    output logic        [4:0]     o_element_count,
    output logic signed [31:0]    o_element_value,
    output logic                  o_element_valid,
    output logic                  o_last
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    logic [31:0]   r_cell [DEPTH];
    logic [31:0]   n_cell [DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] idx;
    logic [CW-1:0] last_idx;
    logic [PW-1:0] pos_w, cnt_w;
    logic [4:0]    pos_m1;

    logic          r_out_valid;
    t_status       r_status;
    logic [4:0]    r_out_count;
    logic [31:0]   r_out_value;
    logic          r_out_elem;
    logic          r_out_last;

    assign pos_w    = PW'(i_position);
    assign cnt_w    = PW'(r_count);
    assign pos_m1   = i_position - 5'd1;
    assign last_idx = r_count - CW'(1);

    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
    assign o_stat.del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    assign o_stat.rd_last    = (r_left == CW'(1));
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    always_comb begin
        unique case (i_cmd.where)
            WH_FRONT: idx = '0;
            WH_BACK:  idx = (i_cmd.op == OP_INSERT) ? r_count : last_idx;
            WH_POS:   idx = CW'(pos_m1);
            default:  idx = '0;
        endcase
    end

    // Each cell picks from itself, its neighbors, the front cell or the new value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] prev_v, next_v;
        if (g == 0) begin : g_first
            assign prev_v = r_cell[g];
        end else begin : g_prev
            assign prev_v = r_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign next_v = r_cell[g];
        end else begin : g_next
            assign next_v = r_cell[g+1];
        end

        always_comb begin
            n_cell[g] = r_cell[g];
            unique case (i_cmd.op)
                OP_INSERT: begin
                    if (CW'(g) == idx) begin
                        n_cell[g] = i_value;
                    end else if (CW'(g) > idx) begin
                        n_cell[g] = prev_v;
                    end
                end
                OP_DELETE: begin
                    if (CW'(g) >= idx) begin
                        n_cell[g] = next_v;
                    end
                end
                OP_ROTATE: begin
                    if (CW'(g) < last_idx) begin
                        n_cell[g] = next_v;
                    end else if (CW'(g) == last_idx) begin
                        n_cell[g] = r_cell[0];
                    end
                end
                default: n_cell[g] = r_cell[g];
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_INSERT: n_count = r_count + CW'(1);
            OP_DELETE: n_count = r_count - CW'(1);
            default:   n_count = r_count;
        endcase
        n_left = r_left;
        if (i_cmd.rd_start) begin
            n_left = r_count;
        end else if (i_cmd.op == OP_ROTATE) begin
            n_left = r_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.out_load) begin
            r_status    <= i_cmd.status;
            r_out_count <= 5'(n_count);
            r_out_value <= i_cmd.out_elem ? r_cell[0] : 32'd0;
            r_out_elem  <= i_cmd.out_elem;
            r_out_last  <= !i_cmd.out_elem || o_stat.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_element_count = r_out_count;
    assign o_element_value = r_out_value;
    assign o_element_valid = r_out_elem;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

[sv/ple_ctrl.sv]
// Controller of the positional list engine: request decode and read-out sequencing.
`default_nettype none

module ple_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_func,
    output logic           o_stall,
    input  ple_pkg::t_stat i_stat,
    output ple_pkg::t_cmd  o_cmd
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_HOLD;
        o_cmd.where    = WH_FRONT;
        o_cmd.rd_start = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.out_elem = 1'b0;
        o_cmd.status   = STAT_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.out_load = 1'b1;
                    unique case (i_func)
                        FUNC_INS_FRONT, FUNC_INS_BACK: begin
                            o_cmd.where = (i_func == FUNC_INS_BACK) ? WH_BACK : WH_FRONT;
                            if (i_stat.full) begin
                                o_cmd.status = STAT_FULL;
                            end else begin
                                o_cmd.op = OP_INSERT;
                            end
                        end
                        FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
                            o_cmd.where = (i_func == FUNC_DEL_BACK) ? WH_BACK : WH_FRONT;
                            if (i_stat.empty) begin
                                o_cmd.status = STAT_EMPTY;
                            end else begin
                                o_cmd.op = OP_DELETE;
                            end
                        end
                        FUNC_INS_AT: begin
                            o_cmd.where = WH_POS;
                            priority if (!i_stat.ins_pos_ok) begin
                                o_cmd.status = STAT_BADPOS;
                            end else if (i_stat.full) begin
                                o_cmd.status = STAT_FULL;
                            end else begin
                                o_cmd.op = OP_INSERT;
                            end
                        end
                        FUNC_DEL_AT: begin
                            o_cmd.where = WH_POS;
                            if (!i_stat.del_pos_ok) begin
                                o_cmd.status = STAT_BADPOS;
                            end else begin
                                o_cmd.op = OP_DELETE;
                            end
                        end
                        FUNC_READ_ALL: begin
                            if (i_stat.empty) begin
                                o_cmd.status = STAT_EMPTY;
                            end else begin
                                o_cmd.out_load = 1'b0;
                                o_cmd.rd_start = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                        default: o_cmd.status = STAT_BADPOS;
                    endcase
                end
            end
            S_READ: begin
                // emit the front cell and rotate the list by one
                if (i_stat.out_free) begin
                    o_cmd.op       = OP_ROTATE;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_elem = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
